// File: rtl/binary32_adder_unit_assert.svh
// Assertion macros for the binary32 adder unit.
// Used by the controller and top level; depends on nothing else.
`ifndef BINARY32_ADDER_UNIT_ASSERT_SVH
`define BINARY32_ADDER_UNIT_ASSERT_SVH
`define B32A_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define B32A_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/b32a_pkg.sv
// Shared types and constants for the binary32 adder unit.
// No dependencies.
package b32a_pkg;
   localparam int unsigned ExpWidth = 8;
   localparam int unsigned FracWidth = 23;
   localparam int unsigned ManWidth = FracWidth + 1;
   localparam int unsigned ShiftLimit = 24;
   localparam logic [ManWidth-1:0] HiddenOne = ManWidth'(1) << FracWidth;

   typedef struct packed {
      logic load;
      logic align;
      logic addsub;
      logic norm_step;
   } dp_cmd_type;

   typedef struct packed {
      logic zero;
      logic normalized;
   } dp_stat_type;
endpackage

// File: rtl/b32a_ctrl.sv
// Controller state machine for the binary32 adder unit.
// Depends on b32a_pkg and binary32_adder_unit_assert.svh.
`include "binary32_adder_unit_assert.svh"
module b32a_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  b32a_pkg::dp_stat_type stat,
   output b32a_pkg::dp_cmd_type  cmd
);
   typedef enum logic [2:0] {S_IDLE, S_ALIGN, S_ADD, S_NORM, S_DONE} state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_ALIGN;
            end
         end
         S_ALIGN: begin
            cmd.align = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.addsub = 1'b1;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (stat.zero || stat.normalized) state_in = S_DONE;
            else cmd.norm_step = 1'b1;
         end
         S_DONE: begin
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = S_ALIGN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = (state_ff == S_DONE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   `B32A_ASSERT_IMPL(a_load_ready, clock, reset, cmd.load, req_ready && req_valid)
   `B32A_ASSERT_NEXT(a_load_align, clock, reset, cmd.load, state_ff == S_ALIGN)
   `B32A_ASSERT_IMPL(a_norm_only, clock, reset, cmd.norm_step, !stat.zero && !stat.normalized)
endmodule

// File: rtl/b32a_dp.sv
// Datapath for the binary32 adder unit: swap, align, add, normalize.
// Depends on b32a_pkg.
module b32a_dp (
   input  logic                  clock,
   input  logic [31:0]           req_operand_a,
   input  logic [31:0]           req_operand_b,
   input  b32a_pkg::dp_cmd_type  cmd,
   output b32a_pkg::dp_stat_type stat,
   output logic [31:0]           rsp_sum_word
);
   localparam int unsigned EW = b32a_pkg::ExpWidth;
   localparam int unsigned MW = b32a_pkg::ManWidth;
   localparam int unsigned FW = b32a_pkg::FracWidth;

   logic          sign_ff, sub_ff;
   logic [EW-1:0] exp_ff, diff_ff;
   logic [MW-1:0] man_big_ff, man_small_ff;
   logic [MW:0]   man_ff;

   logic          swap;
   logic [31:0]   big, small_w;
   logic [EW-1:0] exp_big, exp_small;

   assign swap = req_operand_a[30:0] < req_operand_b[30:0];
   assign big = swap ? req_operand_b : req_operand_a;
   assign small_w = swap ? req_operand_a : req_operand_b;
   assign exp_big = big[30:23];
   assign exp_small = small_w[30:23];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sign_ff <= big[31];
         sub_ff <= big[31] ^ small_w[31];
         exp_ff <= exp_big;
         diff_ff <= exp_big - exp_small;
         man_big_ff <= b32a_pkg::HiddenOne | MW'(big[FW-1:0]);
         man_small_ff <= b32a_pkg::HiddenOne | MW'(small_w[FW-1:0]);
      end else if (cmd.align) begin
         if (diff_ff >= EW'(b32a_pkg::ShiftLimit)) man_small_ff <= '0;
         else man_small_ff <= man_small_ff >> diff_ff;
      end else if (cmd.addsub) begin
         if (sub_ff) man_ff <= {1'b0, man_big_ff} - {1'b0, man_small_ff};
         else man_ff <= {1'b0, man_big_ff} + {1'b0, man_small_ff};
      end else if (cmd.norm_step && man_ff[MW]) begin
         man_ff <= man_ff >> 1;
         exp_ff <= exp_ff + EW'(1);
      end else if (cmd.norm_step) begin
         man_ff <= man_ff << 1;
         exp_ff <= exp_ff - EW'(1);
      end
   end

   assign stat.zero = (man_ff == '0);
   assign stat.normalized = man_ff[MW-1] && !man_ff[MW];
   assign rsp_sum_word = stat.zero ? 32'd0 : {sign_ff, exp_ff, man_ff[FW-1:0]};
endmodule

// File: rtl/binary32_adder_unit.sv
// Top level of the binary32 adder unit.
// Depends on b32a_pkg, b32a_ctrl, b32a_dp and the assertion header.
// One operand pair at a time: states ALIGN and ADD align and add, then NORM
// checks the sum and shifts it right once when it carries out, or left once
// per leading zero (up to 23 shifts); the result beat then waits in DONE;
// the next pair is taken in the cycle the result is taken.
`include "binary32_adder_unit_assert.svh"
module binary32_adder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_sum_word
);
   b32a_pkg::dp_cmd_type  cmd;
   b32a_pkg::dp_stat_type stat;

   b32a_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .stat(stat), .cmd(cmd)
   );

   b32a_dp u_dp (
      .clock(clock), .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .cmd(cmd), .stat(stat), .rsp_sum_word(rsp_sum_word)
   );

   `B32A_ASSERT_IMPL(a_valid_norm, clock, reset, rsp_valid, stat.zero || stat.normalized)
   `B32A_ASSERT_IMPL(a_zero_word, clock, reset, rsp_valid && stat.zero, rsp_sum_word == 32'd0)
   `B32A_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule
